[rtl/core/quicksort_first_pivot_top_defines.svh]
// Assertion macros shared by the sorter RTL.
`ifndef QUICKSORT_FIRST_PIVOT_TOP_DEFINES_SVH
`define QUICKSORT_FIRST_PIVOT_TOP_DEFINES_SVH

// Assert that a condition implies a consequence in the same cycle.
`define QS_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Assert that a condition implies a consequence in the next cycle.
`define QS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[rtl/core/qsfp_pkg.sv]
package qsfp_pkg;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_LOAD,
    ST_POP,
    ST_PIV,
    ST_SCAN_I,
    ST_SCAN_J,
    ST_SWAP_RD,
    ST_SWAP_WR,
    ST_FIN_RD,
    ST_FIN_WR,
    ST_PUSH,
    ST_OUT_RD,
    ST_OUT
  } state_e;

  // Port command from the sequencer to the element memory.
  typedef struct packed {
    logic       rd_en;
    logic [5:0] rd_addr;
    logic       wr_en;
    logic [5:0] wr_addr;
    logic [31:0] wr_data;
  } mem_cmd_t;

endpackage

[rtl/core/qsfp_store.sv]
module qsfp_store #(
  parameter int Depth = 64,
  parameter int AddrW = 6
) (
  input  logic                 clk_i,
  input  logic                 rd_en_i,
  input  logic [AddrW-1:0]     rd_addr_i,
  input  logic                 wr_en_i,
  input  logic [AddrW-1:0]     wr_addr_i,
  input  logic [31:0]          wr_data_i,
  output logic [31:0]          rd_data_o
);

  logic [31:0] mem_q [Depth];

  // One write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_o <= mem_q[rd_addr_i];
    end
  end

endmodule

[rtl/core/quicksort_first_pivot_top.sv]
// Channel  Direction  Signals
// input    in         start_i, busy_o, value_i, last_i
// result   out        valid_o, sorted_value_o, final_res_o, dropped_o
//
// Loading takes an element whenever start_i is high and busy_o low, so elements
// can follow back to back. After the last element the sort runs on one shared
// compare unit and an element memory with one read and one write port. A swap
// is a read state followed by a write state, and each range popped passes
// through pop, pivot read, pivot capture, final swap and push. Each result then
// leaves through a memory read, then output.
// Reset is asynchronous, active low, and clears all control state.
// The receiver cannot stall: each result is valid for exactly one cycle.
module quicksort_first_pivot_top #(
  parameter int MAX_ELEMENTS = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [31:0] value_i,
  input  logic        last_i,
  output logic        valid_o,
  output logic [31:0] sorted_value_o,
  output logic        final_res_o,
  output logic        dropped_o
);

`include "quicksort_first_pivot_top_defines.svh"

  localparam int AW = 6;
  localparam int CW = 7;
  localparam logic [CW-1:0] MaxCnt = CW'(MAX_ELEMENTS);

  qsfp_pkg::state_e state_q, state_d;
  qsfp_pkg::mem_cmd_t cmd;
  logic [31:0] rd_data;

  logic [CW-1:0] cnt_q, cnt_d;
  logic          ovf_q, ovf_d;
  logic [AW-1:0] lo_q, lo_d, hi_q, hi_d, i_q, i_d, j_q, j_d;
  logic [31:0]   piv_q, piv_d, tmp_q, tmp_d;
  logic [CW-1:0] sp_q, sp_d;
  logic [CW-1:0] k_q, k_d;
  logic          push2_q, push2_d;
  logic [2*AW-1:0] stk_q [MAX_ELEMENTS];
  logic          stk_we;
  logic [CW-1:0] stk_wa;
  logic [2*AW-1:0] stk_wd;
  logic [CW-1:0] stk_ra;
  logic [2*AW-1:0] stk_top_q;
  logic          le_piv;
  logic          acc;

  assign acc = start_i && !busy_o;
  assign busy_o = (state_q != qsfp_pkg::ST_LOAD);
  assign le_piv = ($signed(rd_data) <= $signed(piv_q));
  assign stk_ra = sp_d - CW'(1);

  qsfp_store #(.Depth(MAX_ELEMENTS), .AddrW(AW)) u_store (
    .clk_i    (clk_i),
    .rd_en_i  (cmd.rd_en),
    .rd_addr_i(cmd.rd_addr),
    .wr_en_i  (cmd.wr_en),
    .wr_addr_i(cmd.wr_addr),
    .wr_data_i(cmd.wr_data),
    .rd_data_o(rd_data)
  );

  // Range stack memory. The top entry is read into a register every cycle, and a
  // push to the new top in the same cycle is forwarded.
  always_ff @(posedge clk_i) begin
    if (stk_we) begin
      stk_q[AW'(stk_wa)] <= stk_wd;
    end
    if (stk_we && (stk_wa == stk_ra)) begin
      stk_top_q <= stk_wd;
    end else begin
      stk_top_q <= stk_q[AW'(stk_ra)];
    end
  end

  // State and control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= qsfp_pkg::ST_LOAD;
      cnt_q   <= '0;
      ovf_q   <= 1'b0;
      sp_q    <= '0;
      k_q     <= '0;
      push2_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      ovf_q   <= ovf_d;
      sp_q    <= sp_d;
      k_q     <= k_d;
      push2_q <= push2_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    lo_q  <= lo_d;
    hi_q  <= hi_d;
    i_q   <= i_d;
    j_q   <= j_d;
    piv_q <= piv_d;
    tmp_q <= tmp_d;
  end

  // Next state and register updates.
  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q; ovf_d = ovf_q; sp_d = sp_q; k_d = k_q; push2_d = push2_q;
    lo_d = lo_q; hi_d = hi_q; i_d = i_q; j_d = j_q; piv_d = piv_q; tmp_d = tmp_q;
    stk_we = 1'b0; stk_wa = sp_q; stk_wd = '0;
    case (state_q)
      qsfp_pkg::ST_LOAD: begin
        if (acc) begin
          if (cnt_q < MaxCnt) cnt_d = cnt_q + CW'(1);
          else ovf_d = 1'b1;
          if (last_i) begin
            k_d = '0;
            if (cnt_d >= CW'(2)) begin
              stk_we = 1'b1;
              stk_wa = '0;
              stk_wd = {AW'(cnt_d - CW'(1)), AW'(0)};
              sp_d = CW'(1);
              state_d = qsfp_pkg::ST_POP;
            end else begin
              state_d = qsfp_pkg::ST_OUT_RD;
            end
          end
        end
      end
      qsfp_pkg::ST_POP: begin
        if (sp_q == '0) begin
          state_d = qsfp_pkg::ST_OUT_RD;
        end else begin
          sp_d = sp_q - CW'(1);
          lo_d = stk_top_q[AW-1:0];
          hi_d = stk_top_q[2*AW-1:AW];
          i_d  = stk_top_q[AW-1:0];
          j_d  = stk_top_q[2*AW-1:AW];
          if (stk_top_q[AW-1:0] < stk_top_q[2*AW-1:AW]) state_d = qsfp_pkg::ST_PIV;
        end
      end
      qsfp_pkg::ST_PIV: begin
        state_d = qsfp_pkg::ST_SCAN_I;
      end
      qsfp_pkg::ST_SCAN_I: begin
        // First cycle after PIV captures the pivot; rd_data is store[i].
        // The scan stops at hi, where j also stands when everything is not above
        // the pivot.
        if (i_q == lo_q && j_q == hi_q && !push2_q) begin
          piv_d = rd_data;
          push2_d = 1'b1;
        end else if (le_piv && i_q != hi_q) begin
          i_d = i_q + AW'(1);
        end else begin
          state_d = qsfp_pkg::ST_SCAN_J;
        end
      end
      qsfp_pkg::ST_SCAN_J: begin
        // rd_data is store[j]; j never passes lo since the pivot stops it.
        if (!le_piv) begin
          j_d = j_q - AW'(1);
        end else begin
          tmp_d = rd_data;
          if (i_q < j_q)
            state_d = qsfp_pkg::ST_SWAP_RD;
          else
            state_d = qsfp_pkg::ST_FIN_RD;
        end
      end
      qsfp_pkg::ST_SWAP_RD: begin
        state_d = qsfp_pkg::ST_SWAP_WR;
      end
      qsfp_pkg::ST_SWAP_WR: begin
        // store[i] now holds an element not above the pivot, so the scan resumes
        // at i + 1, which never passes j.
        i_d = i_q + AW'(1);
        state_d = qsfp_pkg::ST_SCAN_I;
      end
      qsfp_pkg::ST_FIN_RD: begin
        state_d = qsfp_pkg::ST_FIN_WR;
      end
      qsfp_pkg::ST_FIN_WR: begin
        push2_d = 1'b0;
        state_d = qsfp_pkg::ST_PUSH;
        if ((AW+1)'(j_q) + (AW+1)'(1) < (AW+1)'(hi_q)) begin
          stk_we = 1'b1;
          stk_wd = {hi_q, AW'(j_q + AW'(1))};
          sp_d = sp_q + CW'(1);
        end
      end
      qsfp_pkg::ST_PUSH: begin
        state_d = qsfp_pkg::ST_POP;
        if (j_q > lo_q + AW'(1)) begin
          stk_we = 1'b1;
          stk_wd = {AW'(j_q - AW'(1)), lo_q};
          sp_d = sp_q + CW'(1);
        end
      end
      qsfp_pkg::ST_OUT_RD: begin
        state_d = qsfp_pkg::ST_OUT;
      end
      qsfp_pkg::ST_OUT: begin
        k_d = k_q + CW'(1);
        if (k_q + CW'(1) >= cnt_q) begin
          cnt_d = '0;
          ovf_d = 1'b0;
          state_d = qsfp_pkg::ST_LOAD;
        end else begin
          state_d = qsfp_pkg::ST_OUT_RD;
        end
      end
      default: state_d = qsfp_pkg::ST_LOAD;
    endcase
  end

  // Memory port commands.
  always_comb begin
    cmd = '0;
    case (state_q)
      qsfp_pkg::ST_LOAD: begin
        cmd.wr_en   = acc && (cnt_q < MaxCnt);
        cmd.wr_addr = AW'(cnt_q);
        cmd.wr_data = value_i;
      end
      qsfp_pkg::ST_PIV: begin
        cmd.rd_en = 1'b1; cmd.rd_addr = lo_q;
      end
      qsfp_pkg::ST_SCAN_I: begin
        cmd.rd_en = 1'b1;
        cmd.rd_addr = (state_d == qsfp_pkg::ST_SCAN_J) ? j_q : i_d;
      end
      qsfp_pkg::ST_SCAN_J: begin
        cmd.rd_en = 1'b1;
        cmd.rd_addr = (state_d == qsfp_pkg::ST_SCAN_J) ? j_d :
                      (state_d == qsfp_pkg::ST_SWAP_RD) ? i_q : lo_q;
      end
      qsfp_pkg::ST_SWAP_RD: begin
        // rd_data holds store[i]; write it to j, then store[j] goes to i.
        cmd.wr_en = 1'b1; cmd.wr_addr = j_q; cmd.wr_data = rd_data;
      end
      qsfp_pkg::ST_SWAP_WR: begin
        cmd.wr_en = 1'b1; cmd.wr_addr = i_q; cmd.wr_data = tmp_q;
        cmd.rd_en = 1'b1; cmd.rd_addr = i_q + AW'(1);
      end
      qsfp_pkg::ST_FIN_RD: begin
        cmd.wr_en = 1'b1; cmd.wr_addr = lo_q; cmd.wr_data = tmp_q;
      end
      qsfp_pkg::ST_FIN_WR: begin
        cmd.wr_en = 1'b1; cmd.wr_addr = j_q; cmd.wr_data = piv_q;
      end
      qsfp_pkg::ST_OUT_RD: begin
        cmd.rd_en = 1'b1; cmd.rd_addr = AW'(k_q);
      end
      default: cmd = '0;
    endcase
  end

  // Result outputs.
  always_comb begin
    valid_o        = (state_q == qsfp_pkg::ST_OUT);
    sorted_value_o = rd_data;
    final_res_o    = valid_o && (k_q + CW'(1) >= cnt_q);
    dropped_o      = valid_o && ovf_q;
  end

  `QS_ASSERT_IMP(a_out_only_when_valid, clk_i, rst_ni, final_res_o, valid_o)
  `QS_ASSERT_IMP(a_cnt_bound, clk_i, rst_ni, 1'b1, cnt_q <= MaxCnt)
  `QS_ASSERT_NEXT(a_final_returns_idle, clk_i, rst_ni, final_res_o, !busy_o)

endmodule

[verif/quicksort_first_pivot_top_tb.sv]
module quicksort_first_pivot_top_tb;

  localparam int MaxElements = 64;
  localparam int WatchdogLimit = 200000;
  localparam int DrainCycles = 40;

  logic        clk_i;
  logic        rst_ni;
  logic        start_i;
  logic        busy_o;
  logic [31:0] value_i;
  logic        last_i;
  logic        valid_o;
  logic [31:0] sorted_value_o;
  logic        final_res_o;
  logic        dropped_o;

  // One expected sorted beat.
  typedef struct packed {
    logic [31:0] value;
    logic        final_flag;
    logic        dropped_flag;
  } sorted_beat_t;

  sorted_beat_t sorted_expect_q[$];
  logic signed [31:0] batch_elems[$];
  bit batch_overflow;
  int fail_count;
  int idle_cycles = 0;
  int send_idle_pct;

  quicksort_first_pivot_top #(
    .MAX_ELEMENTS(MaxElements)
  ) DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start_i       (start_i),
    .busy_o        (busy_o),
    .value_i       (value_i),
    .last_i        (last_i),
    .valid_o       (valid_o),
    .sorted_value_o(sorted_value_o),
    .final_res_o   (final_res_o),
    .dropped_o     (dropped_o)
  );

  // Clock generation.
  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  // Model of one batch: collect elements, sort on the closing beat.
  task automatic predict_element(input logic [31:0] value, input logic last);
    logic signed [31:0] tmp;
    int n;
    if (batch_elems.size() < MaxElements) begin
      batch_elems.push_back(value);
    end else begin
      batch_overflow = 1'b1;
    end
    if (last) begin
      n = batch_elems.size();
      // Simple insertion sort; the order of equal keys does not matter.
      for (int i = 1; i < n; i++) begin
        tmp = batch_elems[i];
        for (int j = i - 1; j >= 0 && batch_elems[j] > tmp; j--) begin
          batch_elems[j + 1] = batch_elems[j];
          batch_elems[j] = tmp;
        end
      end
      for (int k = 0; k < n; k++) begin
        sorted_expect_q.push_back({batch_elems[k], k == n - 1, batch_overflow});
      end
      batch_elems.delete();
      batch_overflow = 1'b0;
    end
  endtask

  // Drive one element and wait until it is taken. start_i stays high until the
  // next element or a drain lowers it.
  task automatic send_element(input logic [31:0] value, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      start_i <= 1'b0;
      @(negedge clk_i);
    end
    start_i <= 1'b1;
    value_i <= value;
    last_i  <= last;
    @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
    predict_element(value, last);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    start_i <= 1'b0;
    while (sorted_expect_q.size() != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  // Result checker.
  always @(posedge clk_i) begin
    sorted_beat_t exp_beat;
    if (rst_ni && valid_o) begin
      if (sorted_expect_q.size() == 0) begin
        $display("%0t: unexpected beat value=%h final=%b dropped=%b", $time,
                 sorted_value_o, final_res_o, dropped_o);
        fail_count++;
      end else begin
        exp_beat = sorted_expect_q.pop_front();
        if (exp_beat.value !== sorted_value_o) begin
          $display("%0t: sorted_value expected %h actual %h", $time, exp_beat.value,
                   sorted_value_o);
          fail_count++;
        end
        if (exp_beat.final_flag !== final_res_o) begin
          $display("%0t: final_res expected %b actual %b", $time, exp_beat.final_flag,
                   final_res_o);
          fail_count++;
        end
        if (exp_beat.dropped_flag !== dropped_o) begin
          $display("%0t: dropped expected %b actual %b", $time, exp_beat.dropped_flag,
                   dropped_o);
          fail_count++;
        end
      end
    end
  end

  // Watchdog on cycles with no accepted beat.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o) || valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WatchdogLimit) begin
      $display("quicksort_first_pivot_top_tb NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic logic [31:0] pick_value(input int mode);
    case (mode)
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return 32'($urandom_range(7)) - 32'd3;
      default: return $urandom;
    endcase
  endfunction

  // Directed edge cases: single element, extremes, duplicates, ascending and descending runs.
  task automatic test_directed();
    send_element(32'h0000_0005, 1'b1);
    send_element(32'h7FFF_FFFF, 1'b0);
    send_element(32'h8000_0000, 1'b0);
    send_element(32'hFFFF_FFFF, 1'b0);
    send_element(32'h0000_0000, 1'b0);
    send_element(32'hFFFF_FFFF, 1'b0);
    send_element(32'h0000_0001, 1'b1);
    send_element(32'h5555_5555, 1'b0);
    send_element(32'hAAAA_AAAA, 1'b1);
    for (int i = 0; i < 4; i++) send_element(32'd9, i == 3);
    for (int i = 0; i < 5; i++) send_element(32'(i), i == 4);
    for (int i = 0; i < 5; i++) send_element(32'(10 - i), i == 4);
  endtask

  // Full store plus discarded elements, including a discarded closing element.
  task automatic test_overflow();
    for (int i = 0; i < MaxElements + 2; i++) begin
      send_element(pick_value($urandom_range(3)), i == MaxElements + 1);
    end
    for (int i = 0; i < MaxElements; i++) begin
      send_element(32'(MaxElements - i), i == MaxElements - 1);
    end
  endtask

  // Random batches, mostly small, under the given sender idle rate.
  task automatic test_random(input int idle_pct, input int items);
    int len;
    int mode;
    send_idle_pct = idle_pct;
    while (items > 0) begin
      len = ($urandom_range(9) == 0) ? $urandom_range(MaxElements, 2) :
                                      $urandom_range(8, 1);
      if (len > items) len = items;
      mode = $urandom_range(3);
      for (int i = 0; i < len; i++) begin
        send_element(pick_value(mode == 3 ? $urandom_range(3) : mode + 2), i == len - 1);
      end
      items -= len;
    end
  endtask

  // Sender holds off until every sorted beat has come.
  task automatic test_pause();
    wait_drained();
    send_element($urandom, 1'b0);
    send_element($urandom, 1'b1);
  endtask

  initial begin
    fail_count = 0;
    send_idle_pct = 0;
    batch_overflow = 1'b0;
    rst_ni = 1'b0;
    start_i = 1'b0;
    value_i = '0;
    last_i = 1'b0;
    repeat (5) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    test_directed();
    test_overflow();
    test_random(0, 20);
    test_pause();
    test_random(73, 20);
    test_random(26, 15);
    test_random(0, 10);
    wait_drained();
    if (fail_count == 0) begin
      $display("quicksort_first_pivot_top_tb OK");
    end else begin
      $display("quicksort_first_pivot_top_tb NOT OK");
    end
    $finish;
  end

endmodule
